[design/pfa_pkg.sv]
// Shared types and constants for the page frame allocator with reference counts.
// No dependencies.
`default_nettype none

package pfa_pkg;

  localparam int unsigned NUM_PAGES_DEF  = 4096;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned FREE_W  = 13;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned ERR_W   = 3;
  localparam int unsigned LOW_W   = 12;
  localparam int unsigned TOP_W   = 13;
  localparam int unsigned CFG_W   = 13;

  localparam logic [LOW_W-1:0]   LOW_RST   = '0;
  localparam logic [TOP_W-1:0]   TOP_RST   = 13'd4096;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [0:0] {
    REG_LOWEST = 1'b0,
    REG_TOP    = 1'b1
  } reg_idx_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 3'd0,
    CMD_FREE  = 3'd1,
    CMD_INC   = 3'd2,
    CMD_DEC   = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 3'd0,
    ERR_EMPTY = 3'd1,
    ERR_ALIGN = 3'd2,
    ERR_RANGE = 3'd3,
    ERR_UNDER = 3'd4,
    ERR_FULL  = 3'd5
  } err_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] phys_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  page_address;
    logic [COUNT_W-1:0] ref_count;
    logic [FREE_W-1:0]  free_pages;
    logic [ERR_W-1:0]   error;
  } rsp_t;

  typedef struct packed {
    logic pop;
    logic push;
  } stk_op_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ref_ctl_t;

endpackage

`default_nettype wire

[design/pfa_ref_table.sv]
// Reference count table: one synchronous RAM with registered read data,
// cleared by a sweep after reset. Depends on pfa_pkg.
`default_nettype none

module pfa_ref_table #(
  parameter int unsigned NUM_PAGES = pfa_pkg::NUM_PAGES_DEF,
  localparam int unsigned IW = $clog2(NUM_PAGES)
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  pfa_pkg::ref_ctl_t                ctl_i,
  input  wire  [IW-1:0]                    rd_idx_i,
  input  wire  [IW-1:0]                    wr_idx_i,
  input  wire  [pfa_pkg::COUNT_W-1:0]      wr_data_i,
  output logic [pfa_pkg::COUNT_W-1:0]      rd_data_o,
  output logic                             ready_o
);

  logic [pfa_pkg::COUNT_W-1:0] mem [NUM_PAGES];
  logic                        clearing_q;
  logic [IW-1:0]               clr_idx_q;
  logic                        we;
  logic [IW-1:0]               waddr;
  logic [pfa_pkg::COUNT_W-1:0] wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clearing_q) begin
      if (clr_idx_q == IW'(NUM_PAGES - 1)) begin
        clearing_q <= 1'b0;
      end
      clr_idx_q <= clr_idx_q + IW'(1);
    end
  end

  assign we    = clearing_q | ctl_i.wr_en;
  assign waddr = clearing_q ? clr_idx_q : wr_idx_i;
  assign wdata = clearing_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctl_i.rd_en) begin
      rd_data_o <= mem[rd_idx_i];
    end
  end

  assign ready_o = ~clearing_q;

endmodule

`default_nettype wire

[design/pfa_free_stack.sv]
// LIFO free-page stack: synchronous RAM of page indices plus depth register.
// Depends on pfa_pkg.
`default_nettype none

module pfa_free_stack #(
  parameter int unsigned NUM_PAGES = pfa_pkg::NUM_PAGES_DEF,
  localparam int unsigned IW = $clog2(NUM_PAGES),
  localparam int unsigned DW = $clog2(NUM_PAGES + 1)
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                rd_en_i,
  input  pfa_pkg::stk_op_t   op_i,
  input  wire  [IW-1:0]      push_page_i,
  output logic [IW-1:0]      rd_page_o,
  output logic [DW-1:0]      depth_o
);

  logic [IW-1:0] mem [NUM_PAGES];
  logic [DW-1:0] depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else if (op_i.pop) begin
      depth_q <= depth_q - DW'(1);
    end else if (op_i.push) begin
      depth_q <= depth_q + DW'(1);
    end
  end

  // top of stack is read on rd_en_i, ahead of the pop that commits it
  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      mem[IW'(depth_q)] <= push_page_i;
    end
    if (rd_en_i && (depth_q != '0)) begin
      rd_page_o <= mem[IW'(depth_q - DW'(1))];
    end
  end

  assign depth_o = depth_q;

endmodule

`default_nettype wire

[design/page_frame_allocator_refcount.sv]
// Top level of the page frame allocator: command sequencer, config registers,
// count table and free stack. Depends on pfa_pkg, pfa_ref_table, pfa_free_stack.
`default_nettype none

// Each command is accepted in ST_IDLE and executed in ST_EXEC. The accept edge
// reads the stack RAM for an allocate, or the count RAM for an in-range free,
// increment, decrement or read; ST_EXEC does the modify and write-back and
// registers the result. The result is shown for one cycle with done_o; busy is
// low in that cycle, so a new command may be started there. There is no result
// backpressure. After reset the count table is cleared one entry per cycle,
// with busy high until the sweep ends; config writes are taken at any time.
module page_frame_allocator_refcount #(
  parameter int unsigned NUM_PAGES  = pfa_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  pfa_pkg::req_t                req_i,
  output logic                         done_o,
  output pfa_pkg::rsp_t                rsp_o,
  input  wire                          cfg_we_i,
  input  wire  [0:0]                   cfg_idx_i,
  input  wire  [pfa_pkg::CFG_W-1:0]    cfg_wdata_i
);

  localparam int unsigned IW  = $clog2(NUM_PAGES);
  localparam int unsigned DW  = $clog2(NUM_PAGES + 1);
  localparam int unsigned XW  = pfa_pkg::ADDR_W - PAGE_SHIFT;
  localparam int unsigned CW0 = (XW > pfa_pkg::TOP_W) ? XW : pfa_pkg::TOP_W;
  localparam int unsigned CW  = (CW0 > DW) ? CW0 : DW;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [pfa_pkg::LOW_W-1:0] lowest_q;
  logic [pfa_pkg::TOP_W-1:0] top_q;

  logic          accept;
  logic [XW-1:0] idx;
  logic          range_ok;
  logic          align_ok;

  logic [pfa_pkg::CMD_W-1:0] cmd_q;
  logic [IW-1:0]             tidx_q;
  logic                      range_ok_q;
  logic                      align_ok_q;

  pfa_pkg::ref_ctl_t           ref_ctl;
  logic [IW-1:0]               ref_wr_idx;
  logic [pfa_pkg::COUNT_W-1:0] ref_wr_data;
  logic [pfa_pkg::COUNT_W-1:0] ref_rd_data;
  logic                        ref_ready;

  pfa_pkg::stk_op_t stk_op;
  logic             stk_rd_en;
  logic [IW-1:0]    stk_page;
  logic [DW-1:0]    stk_depth;
  logic             stk_empty;
  logic             stk_full;

  logic [pfa_pkg::COUNT_W-1:0]   cnt_new;
  logic [DW-1:0]                 depth_after;
  logic [IW+PAGE_SHIFT-1:0]      page_wide;
  pfa_pkg::rsp_t                 rsp_d, rsp_q;
  logic                          done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q <= pfa_pkg::LOW_RST;
      top_q    <= pfa_pkg::TOP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pfa_pkg::REG_LOWEST: lowest_q <= cfg_wdata_i[pfa_pkg::LOW_W-1:0];
        pfa_pkg::REG_TOP:    top_q    <= cfg_wdata_i[pfa_pkg::TOP_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start & ~busy;
  assign idx      = req_i.phys_addr[pfa_pkg::ADDR_W-1:PAGE_SHIFT];
  assign align_ok = (req_i.phys_addr[PAGE_SHIFT-1:0] == '0);
  assign range_ok = (CW'(idx) >= CW'(lowest_q)) && (CW'(idx) < CW'(top_q)) &&
                    (CW'(idx) < CW'(NUM_PAGES));

  assign stk_rd_en = accept && (req_i.command == pfa_pkg::CMD_ALLOC);
  assign stk_empty = (stk_depth == '0);
  assign stk_full  = (stk_depth == DW'(NUM_PAGES));
  assign page_wide = {stk_page, {PAGE_SHIFT{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= req_i.command;
      tidx_q     <= IW'(idx);
      range_ok_q <= range_ok;
      align_ok_q <= align_ok;
    end
  end

  always_comb begin
    ref_ctl.rd_en = accept && range_ok &&
                    (req_i.command inside {pfa_pkg::CMD_FREE, pfa_pkg::CMD_INC,
                                           pfa_pkg::CMD_DEC, pfa_pkg::CMD_READ});
    ref_ctl.wr_en      = 1'b0;
    ref_wr_idx         = tidx_q;
    ref_wr_data        = '0;
    stk_op             = '0;
    cnt_new            = '0;
    depth_after        = stk_depth;
    rsp_d.page_address = '0;
    rsp_d.ref_count    = '0;
    rsp_d.error        = pfa_pkg::ERR_OK;
    if (state_q == ST_EXEC) begin
      case (cmd_q)
        pfa_pkg::CMD_ALLOC: begin
          if (stk_empty) begin
            rsp_d.error = pfa_pkg::ERR_EMPTY;
          end else begin
            stk_op.pop         = 1'b1;
            depth_after        = stk_depth - DW'(1);
            ref_ctl.wr_en      = 1'b1;
            ref_wr_idx         = stk_page;
            ref_wr_data        = pfa_pkg::COUNT_W'(1);
            rsp_d.ref_count    = pfa_pkg::COUNT_W'(1);
            rsp_d.page_address = pfa_pkg::ADDR_W'(page_wide);
          end
        end
        pfa_pkg::CMD_FREE: begin
          if (!align_ok_q) begin
            rsp_d.error = pfa_pkg::ERR_ALIGN;
          end else if (!range_ok_q) begin
            rsp_d.error = pfa_pkg::ERR_RANGE;
          end else begin
            cnt_new = (ref_rd_data != '0) ? ref_rd_data - pfa_pkg::COUNT_W'(1) : '0;
            ref_ctl.wr_en   = 1'b1;
            ref_wr_data     = cnt_new;
            rsp_d.ref_count = cnt_new;
            if (cnt_new == '0) begin
              if (stk_full) begin
                rsp_d.error = pfa_pkg::ERR_FULL;
              end else begin
                stk_op.push = 1'b1;
                depth_after = stk_depth + DW'(1);
              end
            end
          end
        end
        pfa_pkg::CMD_INC: begin
          if (!range_ok_q) begin
            rsp_d.error = pfa_pkg::ERR_RANGE;
          end else begin
            cnt_new = (ref_rd_data == pfa_pkg::COUNT_MAX) ? ref_rd_data :
                      ref_rd_data + pfa_pkg::COUNT_W'(1);
            ref_ctl.wr_en   = 1'b1;
            ref_wr_data     = cnt_new;
            rsp_d.ref_count = cnt_new;
          end
        end
        pfa_pkg::CMD_DEC: begin
          if (!range_ok_q) begin
            rsp_d.error = pfa_pkg::ERR_RANGE;
          end else if (ref_rd_data == '0) begin
            rsp_d.error = pfa_pkg::ERR_UNDER;
          end else begin
            cnt_new         = ref_rd_data - pfa_pkg::COUNT_W'(1);
            ref_ctl.wr_en   = 1'b1;
            ref_wr_data     = cnt_new;
            rsp_d.ref_count = cnt_new;
          end
        end
        pfa_pkg::CMD_READ: begin
          if (!range_ok_q) begin
            rsp_d.error = pfa_pkg::ERR_RANGE;
          end else begin
            rsp_d.ref_count = ref_rd_data;
          end
        end
        default: ;
      endcase
    end
    rsp_d.free_pages = pfa_pkg::FREE_W'(depth_after);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (ref_ready) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_EXEC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  pfa_ref_table #(
    .NUM_PAGES(NUM_PAGES)
  ) u_ref_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ref_ctl),
    .rd_idx_i  (IW'(idx)),
    .wr_idx_i  (ref_wr_idx),
    .wr_data_i (ref_wr_data),
    .rd_data_o (ref_rd_data),
    .ready_o   (ref_ready)
  );

  pfa_free_stack #(
    .NUM_PAGES(NUM_PAGES)
  ) u_free_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (stk_rd_en),
    .op_i        (stk_op),
    .push_page_i (tidx_q),
    .rd_page_o   (stk_page),
    .depth_o     (stk_depth)
  );

  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_EXEC))
    else $error("result strobe without preceding execute cycle");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_op.pop |-> !stk_empty)
    else $error("pop from empty free stack");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_op.push |-> !stk_full)
    else $error("push onto full free stack");

  a_addr_only_on_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.page_address != '0)) |->
      ($past(cmd_q) == pfa_pkg::CMD_ALLOC) && (rsp_o.error == pfa_pkg::ERR_OK))
    else $error("page address given outside a successful allocate");

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for page_frame_allocator_refcount: directed table, then random
// command phases under several page windows.
// Depends on pfa_pkg and the allocator RTL only.

module testbench;
  import pfa_pkg::*;

  localparam int NUM_PAGES  = NUM_PAGES_DEF;
  localparam int PAGE_SHIFT = PAGE_SHIFT_DEF;
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

  typedef enum bit {ROW_CMD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [TOP_W-1:0]  lo;
    logic [TOP_W-1:0]  hi;
    bit                typed;
    rsp_t              exp;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  req_t             req = '0;
  logic             done;
  rsp_t             rsp;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_idx = REG_LOWEST;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // allocator shadow state
  logic [PAGE_W-1:0]  frame_stack [NUM_PAGES];
  logic [FREE_W-1:0]  stack_fill = '0;
  logic [COUNT_W-1:0] page_refs [NUM_PAGES] = '{default: '0};
  logic [LOW_W-1:0]   cfg_lowest = LOW_RST;
  logic [TOP_W-1:0]   cfg_top = TOP_RST;

  rsp_t pending_results [$];
  int   mismatch_count = 0;
  bit   no_idle = 1'b0;

  row_t directed_rows [28] = '{
    '{ROW_CMD, CMD_ALLOC, 24'h000000, 13'd0, 13'd0, 1'b1, '{24'h0, 16'd0, 13'd0, ERR_EMPTY}},
    '{ROW_CMD, CMD_READ,  24'hFFF000, 13'd0, 13'd0, 1'b1, '{24'h0, 16'd0, 13'd0, ERR_OK}},
    '{ROW_CMD, CMD_FREE,  24'h000001, 13'd0, 13'd0, 1'b1, '{24'h0, 16'd0, 13'd0, ERR_ALIGN}},
    '{ROW_CMD, CMD_FREE,  24'h800800, 13'd0, 13'd0, 1'b1, '{24'h0, 16'd0, 13'd0, ERR_ALIGN}},
    '{ROW_CMD, CMD_DEC,   24'h001000, 13'd0, 13'd0, 1'b1, '{24'h0, 16'd0, 13'd0, ERR_UNDER}},
    '{ROW_CMD, CMD_FREE,  24'h000000, 13'd0, 13'd0, 1'b1, '{24'h0, 16'd0, 13'd1, ERR_OK}},
    '{ROW_CMD, CMD_FREE,  24'hFFF000, 13'd0, 13'd0, 1'b1, '{24'h0, 16'd0, 13'd2, ERR_OK}},
    '{ROW_CMD, CMD_ALLOC, 24'h000000, 13'd0, 13'd0, 1'b1,
      '{24'hFFF000, 16'd1, 13'd1, ERR_OK}},
    '{ROW_CMD, CMD_INC,   24'hFFF000, 13'd0, 13'd0, 1'b0, '{24'h0, 16'd0, 13'd0, ERR_OK}},
    '{ROW_CMD, CMD_FREE,  24'hFFF000, 13'd0, 13'd0, 1'b0, '{24'h0, 16'd0, 13'd0, ERR_OK}},
    '{ROW_CMD, CMD_FREE,  24'hFFF000, 13'd0, 13'd0, 1'b0, '{24'h0, 16'd0, 13'd0, ERR_OK}},
    '{ROW_CMD, CMD_ALLOC, 24'h000000, 13'd0, 13'd0, 1'b0, '{24'h0, 16'd0, 13'd0, ERR_OK}},
    '{ROW_CMD, CMD_ALLOC, 24'h000000, 13'd0, 13'd0, 1'b0, '{24'h0, 16'd0, 13'd0, ERR_OK}},
    '{ROW_CMD, CMD_ALLOC, 24'h000000, 13'd0, 13'd0, 1'b1, '{24'h0, 16'd0, 13'd0, ERR_EMPTY}},
    '{ROW_CMD, CMD_RSVD_FIRST, 24'hABCDEF, 13'd0, 13'd0, 1'b1,
      '{24'h0, 16'd0, 13'd0, ERR_OK}},
    '{ROW_CMD, CMD_RSVD_LAST, 24'hFFFFFF, 13'd0, 13'd0, 1'b1,
      '{24'h0, 16'd0, 13'd0, ERR_OK}},
    '{ROW_CMD, CMD_INC,   24'h555000, 13'd0, 13'd0, 1'b0, '{24'h0, 16'd0, 13'd0, ERR_OK}},
    '{ROW_CMD, CMD_READ,  24'h555ABC, 13'd0, 13'd0, 1'b0, '{24'h0, 16'd0, 13'd0, ERR_OK}},
    '{ROW_CFG, CMD_ALLOC, 24'h000000, 13'd16, 13'd32, 1'b0, '{24'h0, 16'd0, 13'd0, ERR_OK}},
    '{ROW_CMD, CMD_FREE,  24'h00F000, 13'd0, 13'd0, 1'b1, '{24'h0, 16'd0, 13'd0, ERR_RANGE}},
    '{ROW_CMD, CMD_FREE,  24'h020000, 13'd0, 13'd0, 1'b1, '{24'h0, 16'd0, 13'd0, ERR_RANGE}},
    '{ROW_CMD, CMD_FREE,  24'h00F001, 13'd0, 13'd0, 1'b1, '{24'h0, 16'd0, 13'd0, ERR_ALIGN}},
    '{ROW_CMD, CMD_INC,   24'h020000, 13'd0, 13'd0, 1'b1, '{24'h0, 16'd0, 13'd0, ERR_RANGE}},
    '{ROW_CMD, CMD_DEC,   24'h00F000, 13'd0, 13'd0, 1'b1, '{24'h0, 16'd0, 13'd0, ERR_RANGE}},
    '{ROW_CMD, CMD_READ,  24'h555000, 13'd0, 13'd0, 1'b1, '{24'h0, 16'd0, 13'd0, ERR_RANGE}},
    '{ROW_CMD, CMD_FREE,  24'h010000, 13'd0, 13'd0, 1'b0, '{24'h0, 16'd0, 13'd0, ERR_OK}},
    '{ROW_CMD, CMD_FREE,  24'h01F000, 13'd0, 13'd0, 1'b0, '{24'h0, 16'd0, 13'd0, ERR_OK}},
    '{ROW_CMD, CMD_ALLOC, 24'h000000, 13'd0, 13'd0, 1'b0, '{24'h0, 16'd0, 13'd0, ERR_OK}}
  };

  page_frame_allocator_refcount u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #2 clk_i = ~clk_i;

  function automatic rsp_t predict_frame_op(req_t r);
    logic [PAGE_W-1:0] pg;
    logic              in_range;
    rsp_t              o;
    pg = r.phys_addr[ADDR_W-1:PAGE_SHIFT];
    in_range = ({1'b0, pg} >= {1'b0, cfg_lowest}) && ({1'b0, pg} < cfg_top);
    o = '0;
    case (r.command)
      CMD_ALLOC: begin
        if (stack_fill == 0) begin
          o.error = ERR_EMPTY;
        end else begin
          stack_fill--;
          pg = frame_stack[stack_fill];
          page_refs[pg] = COUNT_W'(1);
          o.ref_count = COUNT_W'(1);
          o.page_address = ADDR_W'(pg) << PAGE_SHIFT;
        end
      end
      CMD_FREE: begin
        if (r.phys_addr[PAGE_SHIFT-1:0] != '0) begin
          o.error = ERR_ALIGN;
        end else if (!in_range) begin
          o.error = ERR_RANGE;
        end else begin
          if (page_refs[pg] != 0) page_refs[pg]--;
          if (page_refs[pg] == 0) begin
            if (stack_fill >= NUM_PAGES) begin
              o.error = ERR_FULL;
            end else begin
              frame_stack[stack_fill] = pg;
              stack_fill++;
            end
          end
          o.ref_count = page_refs[pg];
        end
      end
      CMD_INC, CMD_DEC, CMD_READ: begin
        if (!in_range) begin
          o.error = ERR_RANGE;
        end else begin
          if (r.command == CMD_INC && page_refs[pg] != COUNT_MAX) begin
            page_refs[pg]++;
          end else if (r.command == CMD_DEC) begin
            if (page_refs[pg] == 0) o.error = ERR_UNDER;
            else page_refs[pg]--;
          end
          o.ref_count = page_refs[pg];
        end
      end
      default: ;
    endcase
    o.free_pages = stack_fill;
    return o;
  endfunction

  function automatic int next_gap();
    if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  task automatic issue(input req_t r, input int gap, input bit typed, input rsp_t typed_rsp);
    rsp_t p;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    p = predict_frame_op(r);
    pending_results.push_back(typed ? typed_rsp : p);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [TOP_W-1:0] lo, input logic [TOP_W-1:0] hi);
    cfg_we <= 1'b1;
    cfg_idx <= REG_LOWEST;
    cfg_wdata <= lo;
    @(posedge clk_i);
    cfg_lowest = lo[LOW_W-1:0];
    cfg_idx <= REG_TOP;
    cfg_wdata <= hi;
    @(posedge clk_i);
    cfg_top = hi;
    cfg_we <= 1'b0;
  endtask

  task automatic draw_request(output req_t r);
    int span;
    int roll;
    int pg;
    span = (cfg_top > cfg_lowest) ? int'(cfg_top) - int'(cfg_lowest) : 0;
    roll = $urandom_range(0, 99);
    if (roll < 24) r.command = CMD_ALLOC;
    else if (roll < 48) r.command = CMD_FREE;
    else if (roll < 66) r.command = CMD_INC;
    else if (roll < 80) r.command = CMD_DEC;
    else if (roll < 95) r.command = CMD_READ;
    else r.command = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
    // mostly a small window of pages inside the managed range
    if (span > 0 && $urandom_range(0, 3) != 0)
      pg = cfg_lowest + $urandom_range(0, (span < 24 ? span : 24) - 1);
    else
      pg = $urandom_range(0, NUM_PAGES - 1);
    roll = $urandom_range(0, 99);
    r.phys_addr = ADDR_W'(pg) << PAGE_SHIFT;
    if (roll < 8) r.phys_addr = ADDR_W'($urandom);
    else if (roll < 20)
      r.phys_addr[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom_range(1, (1 << PAGE_SHIFT) - 1));
  endtask

  task automatic run_phase(input logic [TOP_W-1:0] lo, input logic [TOP_W-1:0] hi,
                           input int count);
    req_t r;
    int   known;
    known = 0;
    wait_idle();
    write_config(lo, hi);
    while (known < count) begin
      draw_request(r);
      issue(r, next_gap(), 1'b0, '0);
      if (r.command <= CMD_READ) known++;
    end
  endtask

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: transfer with nothing pending, expected none, got %h", $time, rsp);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("page_address", want.page_address, rsp.page_address);
        check_field("ref_count", want.ref_count, rsp.ref_count);
        check_field("free_pages", want.free_pages, rsp.free_pages);
        check_field("error", want.error, rsp.error);
      end
    end
  end

  initial begin : stimulus
    req_t r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_config(directed_rows[i].lo, directed_rows[i].hi);
      end else begin
        r.command = directed_rows[i].cmd;
        r.phys_addr = directed_rows[i].addr;
        issue(r, next_gap(), directed_rows[i].typed, directed_rows[i].exp);
      end
    end

    run_phase(13'd0, 13'd4096, 250);
    run_phase(13'd4095, 13'd4096, 250);
    run_phase(13'd0, 13'd1, 250);
    run_phase(13'd100, 13'd164, 250);
    run_phase(TOP_W'($urandom_range(0, 4095)), TOP_W'($urandom_range(1, 4096)), 250);
    run_phase(13'd3000, 13'd200, 250);
    run_phase(13'd0, 13'd4096, 250);

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(8_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
design/pfa_pkg.sv
design/pfa_ref_table.sv
design/pfa_free_stack.sv
design/page_frame_allocator_refcount.sv
verif/testbench.sv
